>>> src/assert_macros.svh
// Assertion helpers for the RTL, included by box_corner_overlap_test.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bco_pkg.sv
`default_nettype none

package bco_pkg;

  localparam int CoordWidth   = 32;
  localparam int AxisWidth    = 16;
  localparam int ExtentWidth  = 31;
  localparam int AxisFracBits = 14;
  localparam int CountWidth   = 8;
  // Working width of projected coordinates and their sums.
  localparam int ValWidth     = 40;
  // Inside-corner tally per test, 0 to 4.
  localparam int TallyWidth   = 3;
  localparam int DivDigitBits = 4;

  localparam logic signed [ValWidth-1:0] CoordMax =
    ValWidth'((longint'(1) <<< (CoordWidth - 1)) - longint'(1));
  localparam logic signed [ValWidth-1:0] CoordMin =
    ValWidth'(-(longint'(1) <<< (CoordWidth - 1)));
  localparam logic signed [AxisWidth-1:0] AxisOne = AxisWidth'(1 << AxisFracBits);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_TEST  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]                    command;
    logic signed [CoordWidth-1:0]  pos_x;
    logic signed [CoordWidth-1:0]  pos_y;
    logic signed [AxisWidth-1:0]   axis_cos;
    logic signed [AxisWidth-1:0]   axis_sin;
    logic [ExtentWidth-1:0]        half_width;
    logic [ExtentWidth-1:0]        half_height;
  } bco_in_t;

  typedef struct packed {
    logic                          hit;
    logic [ExtentWidth-1:0]        penetration;
    logic signed [AxisWidth-1:0]   normal_x;
    logic signed [AxisWidth-1:0]   normal_y;
    logic signed [CoordWidth-1:0]  contact_total_x;
    logic signed [CoordWidth-1:0]  contact_total_y;
    logic [CountWidth-1:0]         contact_count;
  } bco_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bco_div_status_t;

endpackage

`default_nettype wire

>>> src/bco_mul.sv
`default_nettype none

module bco_mul (
  input  logic                                  clk_i,
  input  logic signed [bco_pkg::ValWidth-1:0]   a_i,
  input  logic signed [bco_pkg::AxisWidth-1:0]  b_i,
  output logic signed [bco_pkg::ValWidth-1:0]   res_o
);
  import bco_pkg::*;

  localparam int ProdWidth = ValWidth + AxisWidth;

  logic [ValWidth-1:0]  mag_a;
  logic [AxisWidth-1:0] mag_b;
  logic [ProdWidth-1:0] prod_q;
  logic                 neg_q;
  logic [ProdWidth-1:0] rounded;
  logic [ValWidth-1:0]  mag_r;

  assign mag_a = a_i[ValWidth-1] ? ValWidth'(-a_i) : ValWidth'(a_i);
  assign mag_b = b_i[AxisWidth-1] ? AxisWidth'(-b_i) : AxisWidth'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= ProdWidth'(mag_a) * ProdWidth'(mag_b);
    neg_q  <= a_i[ValWidth-1] ^ b_i[AxisWidth-1];
  end

  // Round half away from zero on the magnitude, then restore the sign.
  assign rounded = prod_q + ProdWidth'(1 << (AxisFracBits - 1));
  assign mag_r   = ValWidth'(rounded >> AxisFracBits);
  assign res_o   = neg_q ? -$signed(mag_r) : $signed(mag_r);

endmodule

`default_nettype wire

>>> src/bco_div.sv
`default_nettype none

module bco_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [bco_pkg::TallyWidth-1:0]       n_i,
  input  logic signed [bco_pkg::ValWidth-1:0]  vx_i,
  input  logic signed [bco_pkg::ValWidth-1:0]  vy_i,
  output bco_pkg::bco_div_status_t             status_o,
  output logic signed [bco_pkg::ValWidth-1:0]  qx_o,
  output logic signed [bco_pkg::ValWidth-1:0]  qy_o
);
  import bco_pkg::*;

  localparam int Digits   = ValWidth / DivDigitBits;
  localparam int CntWidth = $clog2(Digits);

  logic [ValWidth-1:0]   ux_q, uy_q;
  logic [TallyWidth-1:0] rx_q, ry_q, n_q;
  logic                  negx_q, negy_q;
  logic                  busy_q, done_q;
  logic [CntWidth-1:0]   cnt_q;
  logic [ValWidth+TallyWidth-1:0] stepx, stepy;

  // Restoring division, one digit of the numerator per call. The quotient
  // bits shift in at the bottom as the numerator bits leave at the top.
  function automatic logic [ValWidth+TallyWidth-1:0] div_digit(
    input logic [ValWidth-1:0]   u,
    input logic [TallyWidth-1:0] r,
    input logic [TallyWidth-1:0] n
  );
    logic [ValWidth-1:0]   uu;
    logic [TallyWidth:0]   rr;
    uu = u;
    rr = {1'b0, r};
    for (int i = 0; i < DivDigitBits; i++) begin
      rr = {rr[TallyWidth-1:0], uu[ValWidth-1]};
      uu = {uu[ValWidth-2:0], 1'b0};
      if (rr >= {1'b0, n}) begin
        rr = rr - {1'b0, n};
        uu[0] = 1'b1;
      end
    end
    return {rr[TallyWidth-1:0], uu};
  endfunction

  assign stepx = div_digit(ux_q, rx_q, n_q);
  assign stepy = div_digit(uy_q, ry_q, n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntWidth'(Digits - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - CntWidth'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ux_q   <= (vx_i[ValWidth-1] ? ValWidth'(-vx_i) : ValWidth'(vx_i))
                + ValWidth'(n_i >> 1);
      uy_q   <= (vy_i[ValWidth-1] ? ValWidth'(-vy_i) : ValWidth'(vy_i))
                + ValWidth'(n_i >> 1);
      rx_q   <= '0;
      ry_q   <= '0;
      n_q    <= n_i;
      negx_q <= vx_i[ValWidth-1];
      negy_q <= vy_i[ValWidth-1];
    end else if (busy_q) begin
      {rx_q, ux_q} <= stepx;
      {ry_q, uy_q} <= stepy;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign qx_o = negx_q ? -$signed(ux_q) : $signed(ux_q);
  assign qy_o = negy_q ? -$signed(uy_q) : $signed(uy_q);

endmodule

`default_nettype wire

>>> src/box_corner_overlap_test.sv
// Oriented box corner overlap test, 2D fixed point.
// Input channel in_valid_i / in_stall_o carries one command per transaction:
// clear the accumulators, load the reference box, or test a box against it.
// Output channel out_valid_o / out_stall_i returns one result transaction per
// command: hit flag, best penetration and normal, contact totals and count.
// A test stops early when a separating axis is found or no corner lies
// inside; clear, load and unused commands go straight to the result. The
// next command can be accepted once the result is in the output register.
// A test uses the single shared 40x16 multiplier, which computes the 24
// products of a full test one after another, and a divider that averages
// the inside corners.
// One command is worked on at a time; in_stall_o is high from acceptance
// until the result is placed in the output register, which holds it while
// out_stall_i is high. A new command can be accepted while a result waits.
// Reset returns the reference box to an unrotated box of zero size at the
// origin and clears all accumulators and the output register.
`default_nettype none
`include "assert_macros.svh"

module box_corner_overlap_test (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bco_pkg::bco_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bco_pkg::bco_out_t out_data_o
);
  import bco_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_WB, ST_SETUP, ST_EVAL, ST_CHECK,
    ST_DIV_GO, ST_DIV_WAIT, ST_UPDATE, ST_PEN, ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    PH_EXT, PH_CORNER, PH_CONTACT
  } phase_e;

  state_e state_q;
  phase_e phase_q;
  logic [1:0] mop_q, corner_q, pen_q;
  logic [TallyWidth-1:0] n_q;
  logic hit_q;

  bco_in_t item_q;
  logic signed [ValWidth-1:0] dx0_q, dy0_q, ax_q, ay_q, bx_q, by_q;
  logic signed [ValWidth-1:0] dx_q, dy_q, t0_q, t1_q;
  logic signed [ValWidth-1:0] minx_q, maxx_q, miny_q, maxy_q;
  logic signed [ValWidth-1:0] lx_q, ly_q, lxd_q, lyd_q;

  logic signed [CoordWidth-1:0] ref_x_q, ref_y_q, sum_x_q, sum_y_q;
  logic signed [AxisWidth-1:0]  ref_cos_q, ref_sin_q, best_nx_q, best_ny_q;
  logic [ExtentWidth-1:0]       ref_hw_q, ref_hh_q, best_pen_q;
  logic [CountWidth-1:0]        tally_q;

  logic     out_valid_q;
  bco_out_t out_q;

  logic signed [ValWidth-1:0]  mul_a, mul_res;
  logic signed [AxisWidth-1:0] mul_b;
  logic signed [ValWidth-1:0]  rw, rh, hw_ext, hh_ext, px, py;
  logic signed [ValWidth-1:0]  cand, cand_sat, best_ext;
  logic signed [AxisWidth-1:0] cand_nx, cand_ny;
  logic                        corner_in, separated, take;
  logic                        div_start;
  bco_div_status_t             div_status;
  logic signed [ValWidth-1:0]  div_qx, div_qy;

  function automatic logic signed [CoordWidth-1:0] sat_coord(
    input logic signed [ValWidth-1:0] v
  );
    if (v > CoordMax) begin
      return CoordWidth'(CoordMax);
    end else if (v < CoordMin) begin
      return CoordWidth'(CoordMin);
    end
    return CoordWidth'(v);
  endfunction

  assign rw       = $signed(ValWidth'(ref_hw_q));
  assign rh       = $signed(ValWidth'(ref_hh_q));
  assign hw_ext   = $signed(ValWidth'(item_q.half_width));
  assign hh_ext   = $signed(ValWidth'(item_q.half_height));
  assign best_ext = $signed(ValWidth'(best_pen_q));
  assign px       = t0_q;
  assign py       = t1_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (phase_q)
      PH_EXT: begin
        mul_a = mop_q[1] ? hh_ext : hw_ext;
        mul_b = (mop_q == 2'd1 || mop_q == 2'd2) ? item_q.axis_sin : item_q.axis_cos;
      end
      PH_CORNER: begin
        mul_a = (mop_q == 2'd1 || mop_q == 2'd2) ? dy_q : dx_q;
        mul_b = (mop_q == 2'd1 || mop_q == 2'd3) ? ref_sin_q : ref_cos_q;
      end
      PH_CONTACT: begin
        mul_a = mop_q[0] ? lyd_q : lxd_q;
        mul_b = (mop_q == 2'd1 || mop_q == 2'd2) ? ref_sin_q : ref_cos_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bco_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  assign div_start = (state_q == ST_DIV_GO);

  bco_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .n_i      (n_q),
    .vx_i     (lx_q),
    .vy_i     (ly_q),
    .status_o (div_status),
    .qx_o     (div_qx),
    .qy_o     (div_qy)
  );

  assign corner_in = (px >= -rw) && (px <= rw) && (py >= -rh) && (py <= rh);
  assign separated = (maxx_q <= -rw) || (minx_q >= rw) || (maxy_q <= -rh)
                     || (miny_q >= rh) || (n_q == '0);

  always_comb begin
    cand    = '0;
    cand_nx = '0;
    cand_ny = '0;
    case (pen_q)
      2'd0: begin
        cand    = rw - minx_q;
        cand_nx = ref_cos_q;
        cand_ny = ref_sin_q;
      end
      2'd1: begin
        cand    = maxx_q + rw;
        cand_nx = -ref_cos_q;
        cand_ny = -ref_sin_q;
      end
      2'd2: begin
        cand    = rh - miny_q;
        cand_nx = -ref_sin_q;
        cand_ny = ref_cos_q;
      end
      default: begin
        cand    = maxy_q + rh;
        cand_nx = ref_sin_q;
        cand_ny = -ref_cos_q;
      end
    endcase
    cand_sat = (cand > CoordMax) ? CoordMax : cand;
    take     = !cand_sat[ValWidth-1] && (cand_sat != '0)
               && ((best_pen_q == '0) || (cand_sat < best_ext));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_EXT;
      mop_q       <= '0;
      corner_q    <= '0;
      pen_q       <= '0;
      n_q         <= '0;
      hit_q       <= 1'b0;
      item_q      <= '0;
      dx0_q       <= '0;
      dy0_q       <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      bx_q        <= '0;
      by_q        <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      t0_q        <= '0;
      t1_q        <= '0;
      minx_q      <= '0;
      maxx_q      <= '0;
      miny_q      <= '0;
      maxy_q      <= '0;
      lx_q        <= '0;
      ly_q        <= '0;
      lxd_q       <= '0;
      lyd_q       <= '0;
      ref_x_q     <= '0;
      ref_y_q     <= '0;
      ref_cos_q   <= AxisOne;
      ref_sin_q   <= '0;
      ref_hw_q    <= '0;
      ref_hh_q    <= '0;
      best_pen_q  <= '0;
      best_nx_q   <= '0;
      best_ny_q   <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            hit_q <= 1'b0;
            case (in_data_i.command)
              CMD_CLEAR: begin
                best_pen_q <= '0;
                best_nx_q  <= '0;
                best_ny_q  <= '0;
                sum_x_q    <= '0;
                sum_y_q    <= '0;
                tally_q    <= '0;
                state_q    <= ST_FINISH;
              end
              CMD_LOAD: begin
                ref_x_q   <= in_data_i.pos_x;
                ref_y_q   <= in_data_i.pos_y;
                ref_cos_q <= in_data_i.axis_cos;
                ref_sin_q <= in_data_i.axis_sin;
                ref_hw_q  <= in_data_i.half_width;
                ref_hh_q  <= in_data_i.half_height;
                state_q   <= ST_FINISH;
              end
              CMD_TEST: begin
                item_q   <= in_data_i;
                dx0_q    <= ValWidth'(in_data_i.pos_x) - ValWidth'(ref_x_q);
                dy0_q    <= ValWidth'(in_data_i.pos_y) - ValWidth'(ref_y_q);
                n_q      <= '0;
                lx_q     <= '0;
                ly_q     <= '0;
                corner_q <= '0;
                mop_q    <= '0;
                phase_q  <= PH_EXT;
                state_q  <= ST_MUL;
              end
              default: begin
                state_q <= ST_FINISH;
              end
            endcase
          end
        end
        ST_MUL: begin
          state_q <= ST_WB;
        end
        ST_WB: begin
          if (phase_q == PH_EXT) begin
            case (mop_q)
              2'd0:    ax_q <= mul_res;
              2'd1:    ay_q <= mul_res;
              2'd2:    bx_q <= -mul_res;
              default: by_q <= mul_res;
            endcase
          end else begin
            case (mop_q)
              2'd0:    t0_q <= mul_res;
              2'd1:    t0_q <= (phase_q == PH_CORNER) ? t0_q + mul_res : t0_q - mul_res;
              2'd2:    t1_q <= mul_res;
              default: t1_q <= (phase_q == PH_CORNER) ? t1_q - mul_res : t1_q + mul_res;
            endcase
          end
          mop_q <= mop_q + 2'd1;
          if (mop_q == 2'd3) begin
            case (phase_q)
              PH_EXT:    state_q <= ST_SETUP;
              PH_CORNER: state_q <= ST_EVAL;
              default:   state_q <= ST_UPDATE;
            endcase
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_SETUP: begin
          dx_q    <= dx0_q + (corner_q[1] ? ax_q : -ax_q) + (corner_q[0] ? bx_q : -bx_q);
          dy_q    <= dy0_q + (corner_q[1] ? ay_q : -ay_q) + (corner_q[0] ? by_q : -by_q);
          phase_q <= PH_CORNER;
          state_q <= ST_MUL;
        end
        ST_EVAL: begin
          if (corner_q == 2'd0 || px < minx_q) minx_q <= px;
          if (corner_q == 2'd0 || px > maxx_q) maxx_q <= px;
          if (corner_q == 2'd0 || py < miny_q) miny_q <= py;
          if (corner_q == 2'd0 || py > maxy_q) maxy_q <= py;
          if (corner_in) begin
            n_q  <= n_q + TallyWidth'(1);
            lx_q <= lx_q + px;
            ly_q <= ly_q + py;
          end
          corner_q <= corner_q + 2'd1;
          state_q  <= (corner_q == 2'd3) ? ST_CHECK : ST_SETUP;
        end
        ST_CHECK: begin
          state_q <= separated ? ST_FINISH : ST_DIV_GO;
        end
        ST_DIV_GO: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_status.done) begin
            lxd_q   <= div_qx;
            lyd_q   <= div_qy;
            mop_q   <= '0;
            phase_q <= PH_CONTACT;
            state_q <= ST_MUL;
          end
        end
        ST_UPDATE: begin
          sum_x_q <= sat_coord(ValWidth'(sum_x_q) + ValWidth'(ref_x_q) + t0_q);
          sum_y_q <= sat_coord(ValWidth'(sum_y_q) + ValWidth'(ref_y_q) + t1_q);
          if (tally_q != '1) begin
            tally_q <= tally_q + CountWidth'(1);
          end
          pen_q   <= '0;
          state_q <= ST_PEN;
        end
        ST_PEN: begin
          if (take) begin
            best_pen_q <= ExtentWidth'(cand_sat);
            best_nx_q  <= cand_nx;
            best_ny_q  <= cand_ny;
            hit_q      <= 1'b1;
          end
          pen_q <= pen_q + 2'd1;
          if (pen_q == 2'd3) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.hit             <= hit_q;
            out_q.penetration     <= best_pen_q;
            out_q.normal_x        <= best_nx_q;
            out_q.normal_y        <= best_ny_q;
            out_q.contact_total_x <= sum_x_q;
            out_q.contact_total_y <= sum_y_q;
            out_q.contact_count   <= tally_q;
            out_valid_q           <= 1'b1;
            state_q               <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPLY(a_hit_has_pen, clk_i, rst_ni, out_valid_q && out_q.hit, out_q.penetration != '0, "hit reported without a penetration")
  `ASSERT_IMPLY(a_div_while_waiting, clk_i, rst_ni, div_status.busy, state_q == ST_DIV_WAIT, "divider running outside its wait state")
  `ASSERT_IMPLY(a_pen_needs_contact, clk_i, rst_ni, state_q == ST_PEN, n_q != '0, "penetration search without an inside corner")
  `ASSERT_NEXT(a_finish_delivers, clk_i, rst_ni, state_q == ST_FINISH && !out_stall_i, out_valid_q && state_q == ST_IDLE, "finished transaction not delivered")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import bco_pkg::*;

  localparam int Period = 4;
  localparam int CycleLimit = 400000;
  localparam longint CMaxL = 64'sd2147483647;
  localparam longint CMinL = -64'sd2147483648;
  localparam longint ProdLimit = 64'sd1 <<< 56;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bco_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bco_out_t out_data;

  bco_out_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int results_seen = 0;
  int hits_seen = 0;
  bit idle_on = 1'b1;

  longint box_px, box_py, box_cos, box_sin, box_hw, box_hh;
  longint best_pen, best_nx, best_ny, sum_x, sum_y;
  int tally;

  always #(Period / 2) clk = ~clk;

  box_corner_overlap_test u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  function automatic longint fx_mul(longint a, longint b);
    bit neg;
    longint ua, ub, r;
    begin
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      // Operands stay below 2^42 and 2^16, so the product fits in 64 bits.
      r = (ua * ub + 64'sd8192) >>> 14;
      if (r > ProdLimit) r = ProdLimit;
      fx_mul = neg ? -r : r;
    end
  endfunction

  function automatic longint sat32(longint v);
    sat32 = v > CMaxL ? CMaxL : (v < CMinL ? CMinL : v);
  endfunction

  function automatic longint div_near(longint v, longint n);
    longint u, q;
    begin
      u = v < 0 ? -v : v;
      q = (u + n / 2) / n;
      div_near = v < 0 ? -q : q;
    end
  endfunction

  function automatic longint wrap16(longint v);
    logic signed [15:0] w;
    begin
      w = v[15:0];
      wrap16 = w;
    end
  endfunction

  function automatic bit take_pen(longint cand, longint nx, longint ny);
    begin
      if (cand > CMaxL) cand = CMaxL;
      take_pen = 1'b0;
      if (cand > 0 && (best_pen == 0 || cand < best_pen)) begin
        best_pen = cand;
        best_nx = wrap16(nx);
        best_ny = wrap16(ny);
        take_pen = 1'b1;
      end
    end
  endfunction

  function automatic bit overlap_box(bco_in_t t);
    longint dx0, dy0, c, s, hw, hh, ax, ay, bx, by, dx, dy, px, py;
    longint minx, maxx, miny, maxy, lx, ly, n, sx, sy;
    bit h;
    begin
      dx0 = longint'(t.pos_x) - box_px;
      dy0 = longint'(t.pos_y) - box_py;
      c = t.axis_cos;
      s = t.axis_sin;
      hw = t.half_width;
      hh = t.half_height;
      ax = fx_mul(hw, c);
      ay = fx_mul(hw, s);
      bx = -fx_mul(hh, s);
      by = fx_mul(hh, c);
      minx = 0; maxx = 0; miny = 0; maxy = 0; lx = 0; ly = 0; n = 0;
      h = 1'b0;
      for (int k = 0; k < 4; k++) begin
        sx = k[1] ? 1 : -1;
        sy = k[0] ? 1 : -1;
        dx = dx0 + sx * ax + sy * bx;
        dy = dy0 + sx * ay + sy * by;
        px = fx_mul(dx, box_cos) + fx_mul(dy, box_sin);
        py = fx_mul(dy, box_cos) - fx_mul(dx, box_sin);
        if (k == 0 || px < minx) minx = px;
        if (k == 0 || px > maxx) maxx = px;
        if (k == 0 || py < miny) miny = py;
        if (k == 0 || py > maxy) maxy = py;
        if (px >= -box_hw && px <= box_hw && py >= -box_hh && py <= box_hh) begin
          n++;
          lx += px;
          ly += py;
        end
      end
      if (maxx <= -box_hw || minx >= box_hw || maxy <= -box_hh || miny >= box_hh
          || n == 0) begin
        overlap_box = 1'b0;
      end else begin
        lx = div_near(lx, n);
        ly = div_near(ly, n);
        sum_x = sat32(sum_x + box_px + fx_mul(lx, box_cos) - fx_mul(ly, box_sin));
        sum_y = sat32(sum_y + box_py + fx_mul(lx, box_sin) + fx_mul(ly, box_cos));
        if (tally < 255) tally++;
        h |= take_pen(box_hw - minx, box_cos, box_sin);
        h |= take_pen(maxx + box_hw, -box_cos, -box_sin);
        h |= take_pen(box_hh - miny, -box_sin, box_cos);
        h |= take_pen(maxy + box_hh, box_sin, -box_cos);
        overlap_box = h;
      end
    end
  endfunction

  function automatic bco_out_t predict_overlap(bco_in_t t);
    bco_out_t r;
    bit h;
    begin
      h = 1'b0;
      case (t.command)
        CMD_CLEAR: begin
          best_pen = 0; best_nx = 0; best_ny = 0; sum_x = 0; sum_y = 0; tally = 0;
        end
        CMD_LOAD: begin
          box_px = t.pos_x; box_py = t.pos_y;
          box_cos = t.axis_cos; box_sin = t.axis_sin;
          box_hw = t.half_width; box_hh = t.half_height;
        end
        CMD_TEST: h = overlap_box(t);
        default: ;
      endcase
      r.hit = h;
      r.penetration = best_pen[30:0];
      r.normal_x = best_nx[15:0];
      r.normal_y = best_ny[15:0];
      r.contact_total_x = sum_x[31:0];
      r.contact_total_y = sum_y[31:0];
      r.contact_count = tally[7:0];
      predict_overlap = r;
    end
  endfunction

  task automatic send_item(bco_in_t t);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_overlap(t));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (idle_on && !out_stall && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      fork
        begin
          repeat ($urandom_range(1, 4)) @(negedge clk);
          out_stall <= 1'b0;
        end
      join_none
    end
  end

  always @(posedge clk) begin
    bco_out_t want;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (want.hit) hits_seen++;
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bco_in_t make_item(logic [1:0] cmd, longint x, longint y,
                                        longint c, longint s, longint w, longint h);
    bco_in_t t;
    begin
      t.command = cmd;
      t.pos_x = x[31:0];
      t.pos_y = y[31:0];
      t.axis_cos = c[15:0];
      t.axis_sin = s[15:0];
      t.half_width = w[30:0];
      t.half_height = h[30:0];
      make_item = t;
    end
  endfunction

  function automatic longint rand_angle_cos(int a);
    rand_angle_cos = longint'($rtoi(16384.0 * $cos(a * 3.14159265 / 180.0)));
  endfunction

  function automatic longint rand_angle_sin(int a);
    rand_angle_sin = longint'($rtoi(16384.0 * $sin(a * 3.14159265 / 180.0)));
  endfunction

  function automatic bco_in_t random_noise(logic [1:0] cmd);
    bco_in_t t;
    begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom};
      t.command = cmd;
      random_noise = t;
    end
  endfunction

  function automatic bco_in_t random_box(logic [1:0] cmd, int spread);
    int a;
    begin
      a = $urandom_range(0, 359);
      random_box = make_item(cmd,
        $signed($urandom_range(0, 2 * spread)) - spread,
        $signed($urandom_range(0, 2 * spread)) - spread,
        rand_angle_cos(a), rand_angle_sin(a),
        $urandom_range(1, spread), $urandom_range(1, spread));
    end
  endfunction

  task automatic test_directed;
    send_item(make_item(CMD_TEST, 0, 0, 16384, 0, 65536, 65536));
    send_item(make_item(CMD_LOAD, 0, 0, 16384, 0, 2 * 65536, 65536));
    send_item(make_item(CMD_TEST, 65536, 0, 16384, 0, 65536, 65536));
    send_item(make_item(CMD_TEST, 0, 0, 16384, 0, 65536, 65536));
    send_item(make_item(CMD_TEST, 3 * 65536, 0, 16384, 0, 65536, 65536));
    send_item(make_item(CMD_TEST, 0, 65536, 11585, 11585, 32768, 32768));
    send_item(make_item(2'd3, -1, -1, -1, -1, 64'h7fffffff, 64'h7fffffff));
    send_item(make_item(CMD_TEST, 0, 0, -32768, -32768, 65536, 65536));
    send_item(make_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CMD_LOAD, 0, 0, -32768, -32768, 64'h7fffffff, 64'h7fffffff));
    send_item(make_item(CMD_TEST, CMaxL, CMaxL, 32767, 32767, 64'h7fffffff, 64'h7fffffff));
    send_item(make_item(CMD_TEST, CMinL, CMinL, -32768, 32767, 64'h7fffffff, 0));
    send_item(make_item(CMD_TEST, 0, 0, 16384, 16384, 0, 0));
    send_item(make_item(CMD_LOAD, CMaxL, CMaxL, 16384, 0, 64'h7fffffff, 64'h7fffffff));
    for (int i = 0; i < 6; i++) begin
      send_item(make_item(CMD_TEST, CMaxL, CMaxL, 16384, 0, 1 << 28, 1 << 28));
    end
    send_item(make_item(CMD_LOAD, CMinL, CMinL, 16384, 0, 64'h7fffffff, 64'h7fffffff));
    send_item(make_item(CMD_TEST, CMinL, CMinL, 16384, 0, 1 << 28, 1 << 28));
    send_item(make_item(CMD_CLEAR, -1, -1, -1, -1, 64'h7fffffff, 64'h7fffffff));
  endtask

  task automatic test_random_scenes(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) send_item(random_box(CMD_LOAD, 1 << 20));
      else if (r < 8) send_item(random_noise(CMD_CLEAR));
      else if (r < 10) send_item(random_noise(2'd3));
      else if (r < 14) send_item(random_noise(2'($urandom_range(0, 3))));
      else send_item(random_box(CMD_TEST, 1 << 20));
    end
  endtask

  task automatic test_saturation(int n);
    send_item(make_item(CMD_LOAD, CMaxL - 65536, CMinL + 65536, 16384, 0,
                        1 << 30, 1 << 30));
    for (int i = 0; i < n; i++) send_item(random_box(CMD_TEST, 1 << 24));
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  initial begin
    box_px = 0; box_py = 0; box_cos = 16384; box_sin = 0; box_hw = 0; box_hh = 0;
    best_pen = 0; best_nx = 0; best_ny = 0; sum_x = 0; sum_y = 0; tally = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_scenes(900);
    test_saturation(300);
    in_valid <= 1'b0;
    idle_on = 1'b0;
    repeat (5) @(negedge clk);
    test_random_scenes(130);
    drain();
    $display("Covered %0d results, %0d of them hits, over clear, load, test and unused",
             results_seen, hits_seen);
    $display("commands with random handshake gaps and accumulator saturation.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
